// ===== rtl/cfrc_pkg.sv =====
// Package for the command frame receive checker.
// Register indexes, register reset values and the result record type.
// No dependencies.
package cfrc_pkg;

   localparam int unsigned CsrAddrWidth = 4;

   typedef enum logic [1:0] {
      REG_HEADER = 2'd0,
      REG_DEVICE = 2'd1,
      REG_TAIL   = 2'd2
   } csr_index_type;

   localparam logic [7:0] HEADER_RESET = 8'h68;
   localparam logic [7:0] DEVICE_RESET = 8'h04;
   localparam logic [7:0] TAIL_RESET   = 8'h16;

   localparam logic [8:0] POS_MAX = 9'd511;

   typedef struct packed {
      logic       is_verdict;
      logic [7:0] payload_byte;
      logic [7:0] payload_index;
      logic       frame_ok;
      logic [7:0] command_code;
      logic [7:0] payload_len;
   } result_type;

endpackage

// ===== rtl/command_frame_receive_checker.sv =====
// Command frame receive checker: parses frames byte by byte, passes payload
// bytes on and gives one verdict per buffer. Depends on cfrc_pkg.
//
// Usage:
//   req_ channel: one received byte per transfer, req_last_byte flags the
//   final byte of the buffer. Frame: header, device id, command, length L,
//   L payload bytes, checksum, tail (L + 6 bytes).
//   rsp_ channel: a payload result (is_verdict 0) for every payload byte,
//   and one verdict (is_verdict 1) on the flagged byte. Header, id,
//   checksum and tail bytes give no result unless flagged last.
//   CSR port (APB style): expected header at 0x0, device id at 0x4,
//   tail at 0x8. Write only while the block is idle.
// Timing:
//   A byte is registered in the input register; the frame logic behind it
//   decides it, and its result is registered in the result stage for rsp_.
//   One byte per cycle sustained, but while a result waits on a stalled
//   receiver, a byte with a result of its own holds in the input register
//   and req_ready drops; bytes without a result keep flowing.
// Reset: clears frame state, both stages and restores register defaults.
module command_frame_receive_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [7:0]                          req_rx_byte,
   input  logic                                req_last_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_is_verdict,
   output logic [7:0]                          rsp_payload_byte,
   output logic [7:0]                          rsp_payload_index,
   output logic                                rsp_frame_ok,
   output logic [7:0]                          rsp_command_code,
   output logic [7:0]                          rsp_payload_len,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [cfrc_pkg::CsrAddrWidth-1:0]   paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);
   import cfrc_pkg::*;

   // configuration registers
   logic [7:0] header_ff, device_ff, tail_ff;
   logic       csr_write;
   csr_index_type csr_idx;

   // input stage
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   // frame state
   logic [8:0] pos_ff, pos_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] cmd_ff, cmd_in;
   logic [7:0] len_ff, len_in;
   logic [7:0] chk_ff, chk_in;
   logic       fault_ff, fault_in;

   // result stage
   logic       rsp_valid_ff;
   result_type rsp_ff, rsp_in;

   logic [8:0] chk_pos, tail_pos, idx_full;
   logic       is_payload, has_result, advance, frame_ok;

   // ---------------- CSR port ----------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_idx   = csr_index_type'(paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff <= HEADER_RESET;
         device_ff <= DEVICE_RESET;
         tail_ff   <= TAIL_RESET;
      end else if (csr_write) begin
         unique case (csr_idx)
            REG_HEADER: header_ff <= pwdata[7:0];
            REG_DEVICE: device_ff <= pwdata[7:0];
            REG_TAIL:   tail_ff   <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (csr_idx)
         REG_HEADER: prdata[7:0] = header_ff;
         REG_DEVICE: prdata[7:0] = device_ff;
         REG_TAIL:   prdata[7:0] = tail_ff;
         default:    prdata      = '0;
      endcase
   end

   // ---------------- frame logic ----------------
   assign chk_pos  = {1'b0, len_ff} + 9'd4;
   assign tail_pos = {1'b0, len_ff} + 9'd5;
   assign idx_full = pos_ff - 9'd4;

   always_comb begin
      sum_in     = sum_ff;
      cmd_in     = cmd_ff;
      len_in     = len_ff;
      chk_in     = chk_ff;
      fault_in   = fault_ff;
      is_payload = 1'b0;
      if (pos_ff == 9'd0) begin
         if (in_byte_ff != header_ff) fault_in = 1'b1;
      end else if (pos_ff == 9'd1) begin
         if (in_byte_ff != device_ff) fault_in = 1'b1;
         sum_in = sum_ff + in_byte_ff;
      end else if (pos_ff == 9'd2) begin
         cmd_in = in_byte_ff;
         sum_in = sum_ff + in_byte_ff;
      end else if (pos_ff == 9'd3) begin
         len_in = in_byte_ff;
         sum_in = sum_ff + in_byte_ff;
      end else if (pos_ff < chk_pos) begin
         sum_in     = sum_ff + in_byte_ff;
         is_payload = 1'b1;
      end else if (pos_ff == chk_pos) begin
         chk_in = in_byte_ff;
      end else if (pos_ff == tail_pos) begin
         if (!in_last_ff) fault_in = 1'b1;
      end else begin
         fault_in = 1'b1;   // past the tail
      end
      pos_in = (pos_ff != POS_MAX) ? pos_ff + 9'd1 : pos_ff;
   end

   assign frame_ok = !fault_in && (pos_ff >= 9'd4) && (pos_ff == tail_pos) &&
                     (in_byte_ff == tail_ff) && (sum_in == chk_in);

   always_comb begin
      rsp_in = '0;
      rsp_in.command_code = cmd_in;
      rsp_in.payload_len  = len_in;
      if (in_last_ff) begin
         rsp_in.is_verdict = 1'b1;
         rsp_in.frame_ok   = frame_ok;
      end else begin
         rsp_in.payload_byte  = in_byte_ff;
         rsp_in.payload_index = idx_full[7:0];
      end
   end

   assign has_result = in_last_ff || is_payload;
   // bytes without a result never wait on the output register
   assign advance    = in_valid_ff && (!has_result || !rsp_valid_ff || rsp_ready);
   assign req_ready  = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
         in_last_ff <= req_last_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         sum_ff   <= '0;
         cmd_ff   <= '0;
         len_ff   <= '0;
         chk_ff   <= '0;
         fault_ff <= 1'b0;
      end else if (advance) begin
         if (in_last_ff) begin
            pos_ff   <= '0;
            sum_ff   <= '0;
            cmd_ff   <= '0;
            len_ff   <= '0;
            chk_ff   <= '0;
            fault_ff <= 1'b0;
         end else begin
            pos_ff   <= pos_in;
            sum_ff   <= sum_in;
            cmd_ff   <= cmd_in;
            len_ff   <= len_in;
            chk_ff   <= chk_in;
            fault_ff <= fault_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && has_result) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && has_result) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_is_verdict    = rsp_ff.is_verdict;
   assign rsp_payload_byte  = rsp_ff.payload_byte;
   assign rsp_payload_index = rsp_ff.payload_index;
   assign rsp_frame_ok      = rsp_ff.frame_ok;
   assign rsp_command_code  = rsp_ff.command_code;
   assign rsp_payload_len   = rsp_ff.payload_len;

endmodule

// ===== rtl/cfrc_checker.sv =====
// Port-level checks for the command frame receive checker, with the bind
// that attaches them. Depends on the top level's result ports.
module cfrc_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_is_verdict,
   input logic [7:0] rsp_payload_byte,
   input logic [7:0] rsp_payload_index,
   input logic       rsp_frame_ok,
   input logic [7:0] rsp_command_code,
   input logic [7:0] rsp_payload_len
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_is_verdict) &&
      $stable(rsp_frame_ok) && $stable(rsp_payload_byte) &&
      $stable(rsp_payload_index) && $stable(rsp_command_code) &&
      $stable(rsp_payload_len))
      else $error("result changed while stalled");

   a_verdict_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_verdict |-> rsp_payload_byte == 8'd0 &&
      rsp_payload_index == 8'd0)
      else $error("verdict carries payload data");

   a_payload_not_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_verdict |-> !rsp_frame_ok &&
      rsp_payload_index != 8'hFF)
      else $error("bad payload result");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind command_frame_receive_checker cfrc_checker u_cfrc_checker (.*);
